// ===== rtl/core/lmsd_pkg.sv =====
// Shared types and constants for the LED matrix scan driver.
// Depends on nothing; every other file in this block imports it.
`default_nettype none

package lmsd_pkg;

  localparam int SCAN_ROWS  = 8;
  localparam int COLUMNS    = 32;
  localparam int STORE_SIZE = 2 * SCAN_ROWS * COLUMNS;

  localparam int ADDR_W    = $clog2(STORE_SIZE);
  localparam int ROW_W     = $clog2(SCAN_ROWS);
  localparam int COL_W     = $clog2(COLUMNS + 1);

  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int COLOR_W   = 3;
  localparam int SEL_W     = 3;

  localparam logic [TICK_W-1:0] PULSE_RESET = 16'd10;
  localparam logic [TICK_W-1:0] DWELL_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [7:0] {
    PH_BLANK      = 8'b0000_0001,
    PH_DATA       = 8'b0000_0010,
    PH_CLK_RISE   = 8'b0000_0100,
    PH_CLK_HOLD   = 8'b0000_1000,
    PH_LATCH_RISE = 8'b0001_0000,
    PH_LATCH_HOLD = 8'b0010_0000,
    PH_UNBLANK    = 8'b0100_0000,
    PH_DWELL      = 8'b1000_0000
  } phase_t;

  // What a tick does to the colour lines once the store read has returned.
  typedef enum logic [1:0] {
    COP_KEEP      = 2'd0,
    COP_CLEAR_TOP = 2'd1,
    COP_LOAD      = 2'd2
  } color_op_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [COLOR_W-1:0]  data;
  } pix_wr_t;

  typedef struct packed {
    logic                rd_en;
    logic [ADDR_W-1:0]   top_addr;
    logic [ADDR_W-1:0]   bot_addr;
    color_op_t           cop;
  } seq_ctl_t;

  typedef struct packed {
    logic [SEL_W-1:0]    row_sel;
    logic                clk;
    logic                lat;
    logic                oe;
  } pins_t;

endpackage

`default_nettype wire

// ===== rtl/core/lmsd_frame_store.sv =====
// Frame store: one write port and two registered read ports over all pixels.
// Runs a clearing pass after reset. Depends on lmsd_pkg.
`default_nettype none

module lmsd_frame_store (
  input  wire                           clk,
  input  wire                           rst_n,
  input  lmsd_pkg::pix_wr_t             wr,
  input  wire                           rd_en,
  input  wire [lmsd_pkg::ADDR_W-1:0]    rd_top_addr,
  input  wire [lmsd_pkg::ADDR_W-1:0]    rd_bot_addr,
  output logic [lmsd_pkg::COLOR_W-1:0]  rd_top_data,
  output logic [lmsd_pkg::COLOR_W-1:0]  rd_bot_data,
  output logic                          busy
);
  import lmsd_pkg::*;

  logic [COLOR_W-1:0] store_mem [STORE_SIZE];

  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [COLOR_W-1:0] wdata;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      if (clr_cnt_r == ADDR_W'(STORE_SIZE - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    we    = clr_busy_r ? 1'b1 : wr.en;
    waddr = clr_busy_r ? clr_cnt_r : wr.addr;
    wdata = clr_busy_r ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_top_data <= store_mem[rd_top_addr];
      rd_bot_data <= store_mem[rd_bot_addr];
    end
  end

  assign busy = clr_busy_r;

endmodule

`default_nettype wire

// ===== rtl/core/lmsd_sequencer.sv =====
// Scan sequencer: phase machine, column and tick counters, timing registers
// and the control pin levels. Depends on lmsd_pkg.
`default_nettype none

module lmsd_sequencer (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             step,
  input  wire                             cfg_we,
  input  wire [lmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [lmsd_pkg::CFG_W-1:0]       cfg_wdata,
  output lmsd_pkg::seq_ctl_t              ctl,
  output lmsd_pkg::pins_t                 pins
);
  import lmsd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [TICK_W-1:0]  pulse_r, dwell_r;
  pins_t              pins_r, pins_nxt;
  logic [ROW_W-1:0]   row_inc;

  assign row_inc = (32'(row_r) == SCAN_ROWS - 1) ? '0 : row_r + ROW_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    tick_nxt     = tick_r;
    pins_nxt     = pins_r;
    ctl.rd_en    = 1'b0;
    ctl.cop      = COP_KEEP;
    ctl.top_addr = ADDR_W'(32'(row_r) * COLUMNS + 32'(col_r));
    ctl.bot_addr = ADDR_W'((32'(row_r) + SCAN_ROWS) * COLUMNS + 32'(col_r));
    if (step) begin
      case (phase_r)
        PH_BLANK: begin
          pins_nxt  = '{row_sel: SEL_W'(row_r), clk: 1'b0, lat: 1'b0, oe: 1'b1};
          ctl.cop   = COP_CLEAR_TOP;
          col_nxt   = '0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          ctl.rd_en = 1'b1;
          ctl.cop   = COP_LOAD;
          phase_nxt = PH_CLK_RISE;
        end
        PH_CLK_RISE: begin
          pins_nxt.clk = 1'b1;
          tick_nxt     = TICK_W'(1);
          phase_nxt    = PH_CLK_HOLD;
        end
        PH_CLK_HOLD: begin
          if (tick_r >= pulse_r) begin
            pins_nxt.clk = 1'b0;
            col_nxt      = col_r + COL_W'(1);
            phase_nxt    = (32'(col_r) + 1 >= COLUMNS) ? PH_LATCH_RISE : PH_DATA;
          end else begin
            tick_nxt = tick_r + TICK_W'(1);
          end
        end
        PH_LATCH_RISE: begin
          pins_nxt.lat = 1'b1;
          tick_nxt     = TICK_W'(1);
          phase_nxt    = PH_LATCH_HOLD;
        end
        PH_LATCH_HOLD: begin
          if (tick_r >= pulse_r) begin
            pins_nxt.lat = 1'b0;
            phase_nxt    = PH_UNBLANK;
          end else begin
            tick_nxt = tick_r + TICK_W'(1);
          end
        end
        PH_UNBLANK: begin
          pins_nxt.oe = 1'b0;
          tick_nxt    = TICK_W'(1);
          phase_nxt   = PH_DWELL;
        end
        PH_DWELL: begin
          // The tick that ends the dwell already blanks for the next row pair.
          if (tick_r >= dwell_r) begin
            row_nxt   = row_inc;
            pins_nxt  = '{row_sel: SEL_W'(row_inc), clk: 1'b0, lat: 1'b0, oe: 1'b1};
            ctl.cop   = COP_CLEAR_TOP;
            col_nxt   = '0;
            phase_nxt = PH_DATA;
          end else begin
            tick_nxt = tick_r + TICK_W'(1);
          end
        end
        default: begin
          phase_nxt = PH_BLANK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLANK;
      row_r   <= '0;
      col_r   <= '0;
      tick_r  <= '0;
      pins_r  <= '{row_sel: '0, clk: 1'b0, lat: 1'b0, oe: 1'b1};
      pulse_r <= PULSE_RESET;
      dwell_r <= DWELL_RESET;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      tick_r  <= tick_nxt;
      pins_r  <= pins_nxt;
      if (cfg_we && cfg_index == REG_PULSE_TICKS) begin
        pulse_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_DWELL_TICKS) begin
        dwell_r <= cfg_wdata;
      end
    end
  end

  assign pins = pins_r;

endmodule

`default_nettype wire

// ===== rtl/core/led_matrix_scan_driver.sv =====
// Top level of the LED matrix scan driver: input stage, store read stage and
// output register. Depends on lmsd_pkg, lmsd_frame_store and lmsd_sequencer.
//
// Each input word is either a pixel write or one timebase tick, and each
// returns one output word with the panel pin levels after it. The block takes
// one word per clock cycle while in_tready is high, and passes each word through
// the store read stage and then the output register; the read stage holds the
// registered read of the frame store, which feeds the colour lines when a
// column's pixels are presented. The output register lets the next word enter
// while a result waits, and in_tready drops when both stages are full and
// during the clearing pass. After reset the frame store is cleared one pixel per
// cycle, with in_tready held low; configuration writes are taken during that pass.
`default_nettype none

module led_matrix_scan_driver (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [4:0] pixel_x, [8:5] pixel_y, [11:9] pixel_color, [15:12] zero
  input  wire [15:0]                      in_tdata,
  // [0] req_type
  input  wire [0:0]                       in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [2:0] top_color, [5:3] bottom_color, [8:6] row_select, [9] shift_clock,
  // [10] latch_strobe, [11] output_blank, [15:12] zero
  output logic [15:0]                     out_tdata,
  input  wire                             cfg_we,
  input  wire [lmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [lmsd_pkg::CFG_W-1:0]       cfg_wdata
);
  import lmsd_pkg::*;

  logic               in_fire, out_free, store_busy, step;
  logic [4:0]         pix_x;
  logic [3:0]         pix_y;
  logic [COLOR_W-1:0] pix_color;
  pix_wr_t            wr;
  seq_ctl_t           ctl;
  pins_t              pins;
  logic [COLOR_W-1:0] rd_top, rd_bot;

  logic               s1_valid_r, s1_valid_nxt;
  color_op_t          s1_cop_r;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_data_r;
  logic [COLOR_W-1:0] top_r, top_nxt, bot_r, bot_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !store_busy && (!s1_valid_r || out_free);
  assign in_fire   = in_tvalid && in_tready;
  assign step      = in_fire && (in_tuser[0] == REQ_TICK);

  assign pix_x     = in_tdata[4:0];
  assign pix_y     = in_tdata[8:5];
  assign pix_color = in_tdata[11:9];

  always_comb begin
    wr.en   = in_fire && (in_tuser[0] == REQ_PIXEL) &&
              (32'(pix_x) < COLUMNS) && (32'(pix_y) < 2 * SCAN_ROWS);
    wr.addr = ADDR_W'(32'(pix_y) * COLUMNS + 32'(pix_x));
    wr.data = pix_color;
  end

  lmsd_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .pins      (pins)
  );

  lmsd_frame_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .rd_en       (ctl.rd_en),
    .rd_top_addr (ctl.top_addr),
    .rd_bot_addr (ctl.bot_addr),
    .rd_top_data (rd_top),
    .rd_bot_data (rd_bot),
    .busy        (store_busy)
  );

  always_comb begin
    top_nxt = top_r;
    bot_nxt = bot_r;
    case (s1_cop_r)
      COP_LOAD: begin
        top_nxt = rd_top;
        bot_nxt = rd_bot;
      end
      COP_CLEAR_TOP: begin
        top_nxt = '0;
      end
      default: begin
      end
    endcase
    s1_valid_nxt  = in_fire ? 1'b1 : (out_free ? 1'b0 : s1_valid_r);
    out_valid_nxt = (s1_valid_r && out_free) ? 1'b1 :
                    (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      top_r       <= '0;
      bot_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && out_free) begin
        top_r <= top_nxt;
        bot_r <= bot_nxt;
      end
    end
  end

  // The sequencer pins already hold the levels after the word in stage one,
  // since no later word can enter until that word moves on.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cop_r <= step ? ctl.cop : COP_KEEP;
    end
    if (s1_valid_r && out_free) begin
      out_data_r <= {4'b0, pins.oe, pins.lat, pins.clk, pins.row_sel, bot_nxt, top_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    store_busy |-> !in_tready)
    else $error("word accepted during frame store clearing pass");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted word did not reach the read stage");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are full");

  a_lit_pins_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !pins.oe |-> (!pins.clk && !pins.lat))
    else $error("shift clock or latch active while panel is lit");
`endif

endmodule

`default_nettype wire
